@@ src/ssrm_pkg.sv @@
package ssrm_pkg;

    localparam int CHROM_W      = 8;
    localparam int COORD_W      = 32;
    localparam int ADJ_W        = 18;
    localparam int CUTOFF_W     = 17;
    localparam int LOD_W        = 24;
    localparam int DIFF_W       = 18;
    localparam int SITE_COUNT_W = 16;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd3277;

    // item action codes
    localparam logic ACT_SITE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_KICK,
        SEQ_DIV_LOD,
        SEQ_DIV_DIFF,
        SEQ_LOAD
    } t_seq_state;

    // tracker status toward the sequencer
    typedef struct packed {
        logic region_open;
        logic emit;
    } t_trk_status;

endpackage

@@ src/ssrm_divider.sv @@
module ssrm_divider #(
    parameter int DW = 40,
    parameter int VW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [$clog2(DW+1)-1:0]       i_steps,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [VW-1:0]                 i_divisor,
    output logic                          o_done,
    output logic [DW-1:0]                 o_quotient
);

    localparam int SW = $clog2(DW+1);

    logic          r_busy, n_busy;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_dvs;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;

    logic [VW:0]   w_shift;
    logic [VW:0]   w_sub;
    logic          w_ge;

    // restoring step: dividend shifts out the top, quotient bits in the bottom
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_sub   = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                n_rem = w_ge ? w_sub[VW-1:0] : w_shift[VW-1:0];
                n_quo = {r_quo[DW-2:0], w_ge};
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

@@ src/ssrm_tracker.sv @@
module ssrm_tracker #(
    parameter int COUNT_BITS = 16,
    parameter int POS_BITS   = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_accept,
    input  logic [ssrm_pkg::CUTOFF_W-1:0]                i_cutoff,
    input  logic                                         i_action,
    input  logic [ssrm_pkg::CHROM_W-1:0]                 i_chrom_id,
    input  logic [ssrm_pkg::COORD_W-1:0]                 i_site_start,
    input  logic [ssrm_pkg::COORD_W-1:0]                 i_site_end,
    input  logic signed [ssrm_pkg::ADJ_W-1:0]            i_adjusted_pvalue,
    input  logic [ssrm_pkg::CUTOFF_W-1:0]                i_unadjusted_pvalue,
    input  logic signed [ssrm_pkg::LOD_W-1:0]            i_lod_score,
    input  logic signed [ssrm_pkg::DIFF_W-1:0]           i_methylation_diff,
    output ssrm_pkg::t_trk_status                        o_status,
    output logic [ssrm_pkg::CHROM_W-1:0]                 o_chrom,
    output logic [POS_BITS-1:0]                          o_start,
    output logic [POS_BITS-1:0]                          o_end,
    output logic [COUNT_BITS-1:0]                        o_count,
    output logic [ssrm_pkg::LOD_W+COUNT_BITS-1:0]        o_lod_sum,
    output logic [ssrm_pkg::DIFF_W+COUNT_BITS-1:0]       o_diff_sum
);

    import ssrm_pkg::*;

    localparam int LSW = LOD_W + COUNT_BITS;
    localparam int DSW = DIFF_W + COUNT_BITS;

    logic                     r_open, r_skipped;
    logic [CHROM_W-1:0]       r_chrom;
    logic [POS_BITS-1:0]      r_start, r_end;
    logic [COUNT_BITS-1:0]    r_count;
    logic signed [LSW-1:0]    r_lod_sum;
    logic signed [DSW-1:0]    r_diff_sum;

    logic                     w_flush, w_sig, w_counted, w_break;
    logic [63:0]              w_start64, w_end64;
    logic signed [LSW:0]      w_lod_acc;
    logic signed [DSW:0]      w_diff_acc;
    logic signed [LSW-1:0]    w_lod_sat;
    logic signed [DSW-1:0]    w_diff_sat;

    assign w_flush   = (i_action == ACT_FLUSH);
    assign w_sig     = !i_adjusted_pvalue[ADJ_W-1]
                       && (i_adjusted_pvalue[ADJ_W-2:0] < i_cutoff);
    assign w_counted = (i_unadjusted_pvalue < i_cutoff);
    assign w_break   = r_skipped || (i_chrom_id != r_chrom);

    assign w_start64 = {32'd0, i_site_start};
    assign w_end64   = {32'd0, i_site_end};

    // saturating accumulate at the sum widths
    assign w_lod_acc  = $signed({r_lod_sum[LSW-1], r_lod_sum}) + (LSW+1)'(i_lod_score);
    assign w_diff_acc = $signed({r_diff_sum[DSW-1], r_diff_sum})
                        + (DSW+1)'(i_methylation_diff);
    assign w_lod_sat  = (w_lod_acc[LSW] != w_lod_acc[LSW-1])
                        ? {w_lod_acc[LSW], {(LSW-1){~w_lod_acc[LSW]}}}
                        : w_lod_acc[LSW-1:0];
    assign w_diff_sat = (w_diff_acc[DSW] != w_diff_acc[DSW-1])
                        ? {w_diff_acc[DSW], {(DSW-1){~w_diff_acc[DSW]}}}
                        : w_diff_acc[DSW-1:0];

    always_comb begin
        o_status.region_open = r_open;
        if (w_flush) begin
            o_status.emit = r_open;
        end else begin
            o_status.emit = w_sig && r_open && w_break && (r_lod_sum != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_skipped  <= 1'b0;
            r_chrom    <= '0;
            r_start    <= '0;
            r_end      <= '0;
            r_count    <= '0;
            r_lod_sum  <= '0;
            r_diff_sum <= '0;
        end else if (i_accept) begin
            if (w_flush) begin
                r_skipped <= 1'b0;
                r_open    <= 1'b0;
            end else if (!w_sig) begin
                r_skipped <= 1'b1;
            end else begin
                r_skipped <= 1'b0;
                r_end     <= w_end64[POS_BITS-1:0];
                if (!r_open || w_break) begin
                    r_open     <= 1'b1;
                    r_chrom    <= i_chrom_id;
                    r_start    <= w_start64[POS_BITS-1:0];
                    r_count    <= COUNT_BITS'(1);
                    r_lod_sum  <= w_counted ? LSW'(i_lod_score) : '0;
                    r_diff_sum <= w_counted ? DSW'(i_methylation_diff) : '0;
                end else begin
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (w_counted) begin
                        r_lod_sum  <= w_lod_sat;
                        r_diff_sum <= w_diff_sat;
                    end
                end
            end
        end
    end

    assign o_chrom    = r_chrom;
    assign o_start    = r_start;
    assign o_end      = r_end;
    assign o_count    = r_count;
    assign o_lod_sum  = r_lod_sum;
    assign o_diff_sum = r_diff_sum;

endmodule

@@ src/significant_site_region_merger_core.sv @@
// Merges sorted significant-site beats into regions and emits one region beat
// per closed region. A site beat that closes nothing, or a flush with no open
// region, leaves o_in_stall low. A beat that closes a region (a significant
// site after a gap or on a new chromosome with a nonzero score sum, or a flush
// of an open region) starts a run through one shared radix-2 restoring
// divider, which first divides the score sum (24 + COUNT_BITS quotient bits)
// and then the difference sum (18 + COUNT_BITS bits) by the site count, one
// quotient bit per cycle. o_in_stall is high for the whole of that run. The
// finished region sits in an output register, so the next beat is taken while
// it waits on i_out_stall; only a second closing region waits for that
// register to drain. Means are truncated toward zero and saturate to their
// field range; the site count saturates at 2^COUNT_BITS - 1 and shows its low
// 16 bits. The cutoff is to be written through i_cfg_we / i_cfg_data only
// while the block is idle; the block itself does not enforce this.
module significant_site_region_merger_core #(
    parameter int COUNT_BITS = 16,
    parameter int POS_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [ssrm_pkg::CUTOFF_W-1:0]        i_cfg_data,
    // site channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic [ssrm_pkg::CHROM_W-1:0]         i_chrom_id,
    input  logic [ssrm_pkg::COORD_W-1:0]         i_site_start,
    input  logic [ssrm_pkg::COORD_W-1:0]         i_site_end,
    input  logic signed [ssrm_pkg::ADJ_W-1:0]    i_adjusted_pvalue,
    input  logic [ssrm_pkg::CUTOFF_W-1:0]        i_unadjusted_pvalue,
    input  logic signed [ssrm_pkg::LOD_W-1:0]    i_lod_score,
    input  logic signed [ssrm_pkg::DIFF_W-1:0]   i_methylation_diff,
    // region channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ssrm_pkg::CHROM_W-1:0]         o_region_chrom,
    output logic [ssrm_pkg::COORD_W-1:0]         o_region_start,
    output logic [ssrm_pkg::COORD_W-1:0]         o_region_end,
    output logic [ssrm_pkg::SITE_COUNT_W-1:0]    o_site_count,
    output logic signed [ssrm_pkg::LOD_W-1:0]    o_mean_lod,
    output logic signed [ssrm_pkg::DIFF_W-1:0]   o_mean_diff
);

    import ssrm_pkg::*;

    localparam int LSW = LOD_W + COUNT_BITS;     // score sum width, divider width
    localparam int DSW = DIFF_W + COUNT_BITS;    // difference sum width
    localparam int SW  = $clog2(LSW + 1);

    // quotient limits for the signed output fields
    localparam logic [LSW-1:0] LOD_POS_MAX  = {{(LSW-LOD_W+1){1'b0}}, {(LOD_W-1){1'b1}}};
    localparam logic [LSW-1:0] LOD_NEG_LIM  = {{(LSW-LOD_W){1'b0}}, 1'b1, {(LOD_W-1){1'b0}}};
    localparam logic [LSW-1:0] DIFF_POS_MAX = {{(LSW-DIFF_W+1){1'b0}}, {(DIFF_W-1){1'b1}}};
    localparam logic [LSW-1:0] DIFF_NEG_LIM = {{(LSW-DIFF_W){1'b0}}, 1'b1,
                                               {(DIFF_W-1){1'b0}}};

    // configuration
    logic [CUTOFF_W-1:0] r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_we) begin
            r_cutoff <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // region tracker
    // ------------------------------------------------------------------
    t_seq_state            r_state, n_state;
    logic                  w_in_acc;
    t_trk_status           w_trk;
    logic [CHROM_W-1:0]    w_trk_chrom;
    logic [POS_BITS-1:0]   w_trk_start, w_trk_end;
    logic [COUNT_BITS-1:0] w_trk_count;
    logic [LSW-1:0]        w_trk_lod;
    logic [DSW-1:0]        w_trk_diff;

    assign o_in_stall = (r_state != SEQ_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    ssrm_tracker #(
        .COUNT_BITS (COUNT_BITS),
        .POS_BITS   (POS_BITS)
    ) u_tracker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_in_acc),
        .i_cutoff            (r_cutoff),
        .i_action            (i_action),
        .i_chrom_id          (i_chrom_id),
        .i_site_start        (i_site_start),
        .i_site_end          (i_site_end),
        .i_adjusted_pvalue   (i_adjusted_pvalue),
        .i_unadjusted_pvalue (i_unadjusted_pvalue),
        .i_lod_score         (i_lod_score),
        .i_methylation_diff  (i_methylation_diff),
        .o_status            (w_trk),
        .o_chrom             (w_trk_chrom),
        .o_start             (w_trk_start),
        .o_end               (w_trk_end),
        .o_count             (w_trk_count),
        .o_lod_sum           (w_trk_lod),
        .o_diff_sum          (w_trk_diff)
    );

    // Snapshot of the closing region; the tracker reopens or clears its region
    // on the same beat, so the divider works from this copy.
    logic [CHROM_W-1:0]    r_em_chrom;
    logic [POS_BITS-1:0]   r_em_start, r_em_end;
    logic [COUNT_BITS-1:0] r_em_count;
    logic [LSW-1:0]        r_em_lod;
    logic [DSW-1:0]        r_em_diff;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_trk.emit) begin
            r_em_chrom <= w_trk_chrom;
            r_em_start <= w_trk_start;
            r_em_end   <= w_trk_end;
            r_em_count <= w_trk_count;
            r_em_lod   <= w_trk_lod;
            r_em_diff  <= w_trk_diff;
        end
    end

    // ------------------------------------------------------------------
    // shared divider: magnitudes in, sign applied on the way out
    // ------------------------------------------------------------------
    logic                  w_lod_neg, w_diff_neg;
    logic [LSW-1:0]        w_lod_mag;
    logic [DSW-1:0]        w_diff_mag;
    logic [LSW-1:0]        w_diff_aligned;
    logic [COUNT_BITS-1:0] w_divisor;
    logic                  w_div_start, w_div_done;
    logic [LSW-1:0]        w_div_dvd;
    logic [SW-1:0]         w_div_steps;
    logic [LSW-1:0]        w_quo, w_quo_neg;

    assign w_lod_neg  = r_em_lod[LSW-1];
    assign w_diff_neg = r_em_diff[DSW-1];
    assign w_lod_mag  = w_lod_neg ? (~r_em_lod + 1'b1) : r_em_lod;
    assign w_diff_mag = w_diff_neg ? (~r_em_diff + 1'b1) : r_em_diff;
    // left-aligned so only DSW steps are needed; the pad bits divide to zero
    assign w_diff_aligned = {w_diff_mag, {(LSW-DSW){1'b0}}};
    assign w_divisor  = (r_em_count == '0) ? COUNT_BITS'(1) : r_em_count;

    ssrm_divider #(
        .DW (LSW),
        .VW (COUNT_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_steps    (w_div_steps),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_quo_neg = ~w_quo + 1'b1;

    // saturate the signed means
    logic [LOD_W-1:0]  w_mean_lod;
    logic [DIFF_W-1:0] w_mean_diff;

    always_comb begin
        if (w_lod_neg) begin
            w_mean_lod = (w_quo > LOD_NEG_LIM) ? {1'b1, {(LOD_W-1){1'b0}}}
                                               : w_quo_neg[LOD_W-1:0];
        end else begin
            w_mean_lod = (w_quo > LOD_POS_MAX) ? {1'b0, {(LOD_W-1){1'b1}}}
                                               : w_quo[LOD_W-1:0];
        end
        if (w_diff_neg) begin
            w_mean_diff = (w_quo > DIFF_NEG_LIM) ? {1'b1, {(DIFF_W-1){1'b0}}}
                                                 : w_quo_neg[DIFF_W-1:0];
        end else begin
            w_mean_diff = (w_quo > DIFF_POS_MAX) ? {1'b0, {(DIFF_W-1){1'b1}}}
                                                 : w_quo[DIFF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic w_load;
    logic w_out_acc;

    assign w_out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_dvd   = w_diff_aligned;
        w_div_steps = SW'(DSW);
        w_load      = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_in_acc && w_trk.emit) begin
                    n_state = SEQ_KICK;
                end
            end
            SEQ_KICK: begin
                w_div_start = 1'b1;
                w_div_dvd   = w_lod_mag;
                w_div_steps = SW'(LSW);
                n_state     = SEQ_DIV_LOD;
            end
            SEQ_DIV_LOD: begin
                // score quotient is captured; difference division starts
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state     = SEQ_DIV_DIFF;
                end
            end
            SEQ_DIV_DIFF: begin
                if (w_div_done) begin
                    n_state = SEQ_LOAD;
                end
            end
            SEQ_LOAD: begin
                if (!o_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic [LOD_W-1:0]  r_mean_lod;
    logic [DIFF_W-1:0] r_mean_diff;

    always_ff @(posedge i_clk) begin
        if (w_div_done && (r_state == SEQ_DIV_LOD)) begin
            r_mean_lod <= w_mean_lod;
        end
        if (w_div_done && (r_state == SEQ_DIV_DIFF)) begin
            r_mean_diff <= w_mean_diff;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic [63:0] w_start64, w_end64, w_count64;

    assign w_start64 = 64'(r_em_start);
    assign w_end64   = 64'(r_em_end);
    assign w_count64 = 64'(r_em_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_region_chrom <= r_em_chrom;
            o_region_start <= w_start64[COORD_W-1:0];
            o_region_end   <= w_end64[COORD_W-1:0];
            o_site_count   <= w_count64[SITE_COUNT_W-1:0];
            o_mean_lod     <= r_mean_lod;
            o_mean_diff    <= r_mean_diff;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_emit_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trk.emit |-> w_trk.region_open)
        else $error("region close requested with no region open");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == SEQ_DIV_LOD || r_state == SEQ_DIV_DIFF))
        else $error("divider finished outside a division step");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == SEQ_LOAD))
        else $error("region beat raised without a load step");

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssrm_pkg::*;

    // Build under test: default widths, 16-bit site counter, 32-bit coordinates.
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 32;
    localparam int LOD_ACC_W  = LOD_W + COUNT_W;   // score sum, saturating
    localparam int DIFF_ACC_W = DIFF_W + COUNT_W;  // difference sum, saturating

    localparam int LOD_MAX  = 8388607;
    localparam int LOD_MIN  = -8388608;
    localparam int DIFF_LIM = 65536;               // |diff| and |adj p| field limit

    // Settle wait: longer than a closing region's stall run, with margin.
    localparam int SETTLE_CYCLES = 2 * COUNT_W + 47 + 40;
    // Long receiver hold-off, started once enough regions have come out.
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER  = 30;
    // Length of the long single-chromosome runs at extreme score and difference.
    localparam int SAT_RUN   = 40;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic                      action;
        logic [CHROM_W-1:0]        chrom;
        logic [COORD_W-1:0]        start_pos;
        logic [COORD_W-1:0]        end_pos;
        logic signed [ADJ_W-1:0]   adj_p;
        logic [CUTOFF_W-1:0]       raw_p;
        logic signed [LOD_W-1:0]   lod;
        logic signed [DIFF_W-1:0]  diff;
    } t_site;

    typedef struct packed {
        logic [CHROM_W-1:0]        chrom;
        logic [COORD_W-1:0]        start_pos;
        logic [COORD_W-1:0]        end_pos;
        logic [SITE_COUNT_W-1:0]   count;
        logic signed [LOD_W-1:0]   mean_lod;
        logic signed [DIFF_W-1:0]  mean_diff;
    } t_region;

    // One queued site beat; 'typed' rows carry a hand-written region that
    // replaces the predicted one.
    typedef struct packed {
        t_site   site;
        logic    typed;
        t_region region;
    } t_sched;

    localparam t_region NO_REGION = '0;

    // Directed rows, run at the reset cutoff of 3277.
    localparam t_sched DIRECTED_BEATS [24] = '{
        // flush with nothing open: no beat out
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b0, NO_REGION},
        // single site at every positive extreme, then flushed
        '{'{ACT_SITE, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sh7FFFFF, 18'sh10000},
          1'b0, NO_REGION},
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b1,
          '{8'd0, 32'd0, 32'd0, 16'd1, 24'sh7FFFFF, 18'sh10000}},
        // top chromosome, top coordinates, adj and raw p just under the cutoff
        '{'{ACT_SITE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'sd3276, 17'd3276,
            24'sh800000, -18'sd65536}, 1'b0, NO_REGION},
        // merges; raw p at the cutoff so it is counted but not summed
        '{'{ACT_SITE, 8'd255, 32'd100, 32'd200, 18'sd0, 17'd3277, 24'sd5, 18'sd5},
          1'b0, NO_REGION},
        // gaps: adj p exactly at the cutoff, then a negative (invalid) adj p
        '{'{ACT_SITE, 8'd255, 32'd210, 32'd220, 18'sd3277, 17'd0, 24'sd9, 18'sd9},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd255, 32'd230, 32'd240, -18'sd1, 17'd0, 24'sd9, 18'sd9},
          1'b0, NO_REGION},
        // significant after a gap closes the region
        '{'{ACT_SITE, 8'd255, 32'd300, 32'd400, 18'sd10, 17'd0, 24'sd1000, 18'sd2}, 1'b1,
          '{8'd255, 32'hFFFF_FFFF, 32'd200, 16'd2, -24'sd4194304, -18'sd32768}},
        // new chromosome closes it; this one is not summed (raw p at top)
        '{'{ACT_SITE, 8'd3, 32'd0, 32'd5, 18'sd0, 17'd65536, 24'sd7, 18'sd7}, 1'b1,
          '{8'd255, 32'd300, 32'd400, 16'd1, 24'sd1000, 18'sd2}},
        // new chromosome again, but the score sum is zero: closes silently
        '{'{ACT_SITE, 8'd4, 32'd10, 32'd20, 18'sd0, 17'd0, 24'sd3, 18'sd9},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd4, 32'd25, 32'd26, -18'sd65536, 17'd0, 24'sd0, 18'sd0},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd4, 32'd30, 32'd40, 18'sd0, 17'd0, -24'sd3, 18'sd4}, 1'b1,
          '{8'd4, 32'd10, 32'd20, 16'd1, 24'sd3, 18'sd9}},
        '{'{ACT_SITE, 8'd4, 32'd50, 32'd60, 18'sd1, 17'd3276, 24'sd3, 18'sd7},
          1'b0, NO_REGION},
        // flush emits even though the score sum came back to zero
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b1,
          '{8'd4, 32'd30, 32'd60, 16'd2, 24'sd0, 18'sd5}},
        // second flush, all payload bits set: nothing open, nothing out
        '{'{ACT_FLUSH, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -18'sd1, 17'h1FFFF,
            -24'sd1, -18'sd1}, 1'b0, NO_REGION},
        // gap with nothing open, then a flush that clears the gap flag
        '{'{ACT_SITE, 8'd9, 32'd0, 32'd0, 18'sd65536, 17'd0, 24'sd0, 18'sd0},
          1'b0, NO_REGION},
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b0, NO_REGION},
        // negative sums: means truncate toward zero
        '{'{ACT_SITE, 8'd9, 32'd1, 32'd2, 18'sd0, 17'd0, -24'sd7, -18'sd3},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd9, 32'd3, 32'd4, 18'sd3276, 17'd0, 24'sd2, -18'sd2},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd9, 32'd5, 32'd6, 18'sd65535, 17'd0, 24'sd0, 18'sd0},
          1'b0, NO_REGION},
        // flush of a region that has a gap pending
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd9, 32'd7, 32'd8, 18'sd0, 17'd0, 24'sd1, 18'sd1},
          1'b0, NO_REGION},
        '{'{ACT_SITE, 8'd9, 32'd9, 32'd10, 18'sd0, 17'd65536, 24'sd0, 18'sd0},
          1'b0, NO_REGION},
        '{'{ACT_FLUSH, 8'd0, 32'd0, 32'd0, 18'sd0, 17'd0, 24'sd0, 18'sd0}, 1'b0, NO_REGION}
    };

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CUTOFF_W-1:0]        i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_action = ACT_SITE;
    logic [CHROM_W-1:0]         i_chrom_id = '0;
    logic [COORD_W-1:0]         i_site_start = '0;
    logic [COORD_W-1:0]         i_site_end = '0;
    logic signed [ADJ_W-1:0]    i_adjusted_pvalue = '0;
    logic [CUTOFF_W-1:0]        i_unadjusted_pvalue = '0;
    logic signed [LOD_W-1:0]    i_lod_score = '0;
    logic signed [DIFF_W-1:0]   i_methylation_diff = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [CHROM_W-1:0]         o_region_chrom;
    logic [COORD_W-1:0]         o_region_start;
    logic [COORD_W-1:0]         o_region_end;
    logic [SITE_COUNT_W-1:0]    o_site_count;
    logic signed [LOD_W-1:0]    o_mean_lod;
    logic signed [DIFF_W-1:0]   o_mean_diff;

    significant_site_region_merger_core #(
        .COUNT_BITS (COUNT_W),
        .POS_BITS   (POS_W)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_action            (i_action),
        .i_chrom_id          (i_chrom_id),
        .i_site_start        (i_site_start),
        .i_site_end          (i_site_end),
        .i_adjusted_pvalue   (i_adjusted_pvalue),
        .i_unadjusted_pvalue (i_unadjusted_pvalue),
        .i_lod_score         (i_lod_score),
        .i_methylation_diff  (i_methylation_diff),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_region_chrom      (o_region_chrom),
        .o_region_start      (o_region_start),
        .o_region_end        (o_region_end),
        .o_site_count        (o_site_count),
        .o_mean_lod          (o_mean_lod),
        .o_mean_diff         (o_mean_diff)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_sched  sites_to_send [$];   // beats waiting for the sender
    t_region regions_due [$];     // predicted region beats, oldest first
    t_sched  on_wire;             // beat currently offered on the site channel
    int      beats_queued = 0;
    int      beats_taken  = 0;
    int      regions_seen = 0;
    int      fail_count   = 0;
    int      idle_pct     = 24;   // per-cycle idle chance of both sides, percent
    int      hold_left    = 0;
    bit      hold_done    = 1'b0;

    // Region tracker mirror; cutoff_now follows every register write.
    int                   cutoff_now = CUTOFF_RESET;
    bit                   reg_open  = 1'b0;
    bit                   gap_seen  = 1'b0;
    logic [CHROM_W-1:0]   cur_chrom = '0;
    logic [COORD_W-1:0]   cur_start = '0;
    logic [COORD_W-1:0]   cur_end   = '0;
    logic [COUNT_W-1:0]   cur_count = '0;
    longint               lod_acc   = 0;
    longint               diff_acc  = 0;

    // ------------------------------------------------------------------
    // Region predictor
    // ------------------------------------------------------------------
    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Region beat for the currently open region. Means truncate toward zero
    // and clip to the output field; only a saturated count can push them out.
    function automatic t_region region_now();
        t_region r;
        longint  n;
        n = (cur_count == 0) ? 1 : cur_count;
        r.chrom     = cur_chrom;
        r.start_pos = cur_start;
        r.end_pos   = cur_end;
        r.count     = SITE_COUNT_W'(cur_count);
        r.mean_lod  = LOD_W'(clamp(lod_acc / n, LOD_W));
        r.mean_diff = DIFF_W'(clamp(diff_acc / n, DIFF_W));
        return r;
    endfunction

    task automatic merge_site(input t_sched item);
        t_site   s;
        t_region r;
        longint  adj_v;
        longint  lod_v;
        longint  diff_v;
        bit      counted;
        bit      emitted;
        s       = item.site;
        adj_v   = s.adj_p;
        lod_v   = s.lod;
        diff_v  = s.diff;
        emitted = 1'b0;
        r       = NO_REGION;
        if (s.action == ACT_FLUSH) begin
            // flush empties whatever is open, sum or no sum
            gap_seen = 1'b0;
            if (reg_open) begin
                r        = region_now();
                emitted  = 1'b1;
                reg_open = 1'b0;
            end
        end else if (!(adj_v >= 0 && adj_v < cutoff_now)) begin
            gap_seen = 1'b1;
        end else begin
            counted = int'(s.raw_p) < cutoff_now;
            if (reg_open && !gap_seen && s.chrom == cur_chrom) begin
                cur_end = s.end_pos;
                if (cur_count != {COUNT_W{1'b1}})
                    cur_count++;
                if (counted) begin
                    lod_acc  = clamp(lod_acc + lod_v, LOD_ACC_W);
                    diff_acc = clamp(diff_acc + diff_v, DIFF_ACC_W);
                end
            end else begin
                // a closing region with a zero score sum is dropped
                if (reg_open && lod_acc != 0) begin
                    r       = region_now();
                    emitted = 1'b1;
                end
                reg_open  = 1'b1;
                cur_chrom = s.chrom;
                cur_start = s.start_pos;
                cur_end   = s.end_pos;
                cur_count = 1;
                lod_acc   = counted ? lod_v : 0;
                diff_acc  = counted ? diff_v : 0;
            end
            gap_seen = 1'b0;
        end
        if (item.typed)
            r = item.region;
        if (emitted)
            regions_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_sched mk_site(input logic act, input logic [CHROM_W-1:0] ch,
                                       input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] e,
                                       input int adj, input int raw, input int lod,
                                       input int diff);
        t_sched t;
        t.site.action    = act;
        t.site.chrom     = ch;
        t.site.start_pos = s;
        t.site.end_pos   = e;
        t.site.adj_p     = ADJ_W'(adj);
        t.site.raw_p     = CUTOFF_W'(raw);
        t.site.lod       = LOD_W'(lod);
        t.site.diff      = DIFF_W'(diff);
        t.typed          = 1'b0;
        t.region         = NO_REGION;
        return t;
    endfunction

    // adj p that is significant under the current cutoff, or a gap:
    // either negative or at/above the cutoff
    function automatic int pick_adj(input bit want_sig);
        if (want_sig && cutoff_now > 0)
            return span(0, cutoff_now - 1);
        if ($urandom_range(1))
            return span(-DIFF_LIM, -1);
        return span(cutoff_now, DIFF_LIM);
    endfunction

    // raw p: mostly summed, a quarter of the time left out of the sums
    function automatic int pick_raw();
        if (cutoff_now > 0 && $urandom_range(3) != 0)
            return span(0, cutoff_now - 1);
        return span(cutoff_now, DIFF_LIM);
    endfunction

    function automatic t_sched flush_beat();
        return mk_site(ACT_FLUSH, CHROM_W'($urandom_range(255)), $urandom, $urandom,
                       span(-DIFF_LIM, DIFF_LIM), $urandom_range(DIFF_LIM),
                       span(LOD_MIN, LOD_MAX), span(-DIFF_LIM, DIFF_LIM));
    endfunction

    task automatic queue_site(input t_sched item);
        sites_to_send.push_back(item);
        beats_queued++;
    endtask

    // Mostly sorted runs of significant sites with random content, closed by
    // gaps, flushes or a chromosome change; the rest is unstructured noise.
    task automatic gen_traffic(input int n);
        int                 made;
        int                 len;
        int                 style;
        int                 tail;
        int                 lod;
        int                 k;
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] pos;
        made  = 0;
        chrom = CHROM_W'($urandom_range(255));
        pos   = $urandom;
        while (made < n) begin
            if ($urandom_range(99) < 75) begin
                case ($urandom_range(9))
                    6, 7, 8: chrom = chrom + 1'b1;
                    9:       chrom = CHROM_W'($urandom_range(255));
                    default: ;  // same chromosome: may extend the open region
                endcase
                len   = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
                style = $urandom_range(9);
                for (k = 0; k < len; k++) begin
                    if (style == 0)
                        lod = 0;        // zero score sum: closes silently, but a flush still emits it
                    else if (style == 1)
                        lod = $urandom_range(1) ? LOD_MAX : LOD_MIN;
                    else
                        lod = span(LOD_MIN, LOD_MAX);
                    pos = pos + $urandom_range(500);
                    queue_site(mk_site(ACT_SITE, chrom, pos, pos + $urandom_range(300),
                                       pick_adj(1'b1), pick_raw(), lod,
                                       span(-DIFF_LIM, DIFF_LIM)));
                end
                made += len;
                tail = $urandom_range(99);
                if (tail < 40) begin
                    repeat ($urandom_range(3, 1)) begin
                        queue_site(mk_site(ACT_SITE, chrom, pos, pos, pick_adj(1'b0),
                                           pick_raw(), span(LOD_MIN, LOD_MAX),
                                           span(-DIFF_LIM, DIFF_LIM)));
                        made++;
                    end
                end else if (tail < 55) begin
                    queue_site(flush_beat());
                    made++;
                end
            end else begin
                if ($urandom_range(9) == 0)
                    queue_site(flush_beat());
                else
                    queue_site(mk_site(ACT_SITE, CHROM_W'($urandom_range(255)), $urandom,
                                       $urandom, span(-DIFF_LIM, DIFF_LIM),
                                       $urandom_range(DIFF_LIM), span(LOD_MIN, LOD_MAX),
                                       span(-DIFF_LIM, DIFF_LIM)));
                made++;
            end
        end
        queue_site(flush_beat());
    endtask

    // One long region, all summed, every site at the same extreme score and
    // difference, then flushed.
    task automatic send_long_run(input logic [CHROM_W-1:0] ch, input int lod, input int diff);
        int k;
        for (k = 0; k < SAT_RUN; k++)
            queue_site(mk_site(ACT_SITE, ch, COORD_W'(k * 4), COORD_W'(k * 4 + 3),
                               0, 0, lod, diff));
        queue_site(flush_beat());
    endtask

    task automatic write_cutoff(input int v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CUTOFF_W'(v);
        cutoff_now = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Wait for every queued beat to be taken and every region to come out,
    // then leave some quiet cycles before the next register write.
    task automatic settle();
        while (beats_taken != beats_queued || regions_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
            note_fail($sformatf("region beat %0d, %s: expected %0d, got %0d",
                                regions_seen, name, want, got));
    endtask

    // ------------------------------------------------------------------
    // Site channel sender. Valid is raised independently of stall and the
    // payload holds until the beat is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                merge_site(on_wire);
                beats_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (sites_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    on_wire = sites_to_send.pop_front();
                    i_in_valid          <= 1'b1;
                    i_action            <= on_wire.site.action;
                    i_chrom_id          <= on_wire.site.chrom;
                    i_site_start        <= on_wire.site.start_pos;
                    i_site_end          <= on_wire.site.end_pos;
                    i_adjusted_pvalue   <= on_wire.site.adj_p;
                    i_unadjusted_pvalue <= on_wire.site.raw_p;
                    i_lod_score         <= on_wire.site.lod;
                    i_methylation_diff  <= on_wire.site.diff;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Region channel receiver: random stalls, plus one long hold-off so the
    // output register fills and a second closing region backs up the input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && regions_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Region checker: each beat taken against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_region got;
        t_region want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_region_chrom, o_region_start, o_region_end, o_site_count,
                    o_mean_lod, o_mean_diff};
            regions_seen++;
            if (regions_due.size() == 0) begin
                note_fail($sformatf("region beat %0d not expected: chrom %0d start %0d end %0d",
                                    regions_seen, got.chrom, got.start_pos, got.end_pos));
            end else begin
                want = regions_due.pop_front();
                check_field("region_chrom", want.chrom, got.chrom);
                check_field("region_start", want.start_pos, got.start_pos);
                check_field("region_end", want.end_pos, got.end_pos);
                check_field("site_count", want.count, got.count);
                check_field("mean_lod", want.mean_lod, got.mean_lod);
                check_field("mean_diff", want.mean_diff, got.mean_diff);
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows and a first random phase at the reset cutoff
        foreach (DIRECTED_BEATS[k])
            queue_site(DIRECTED_BEATS[k]);
        gen_traffic(200);
        settle();

        // cutoff 0: nothing is significant, every site is a gap
        write_cutoff(0);
        gen_traffic(40);
        settle();

        // widest cutoff, then the narrowest nonzero one, the widest's neighbor, a random one
        write_cutoff(65536);
        gen_traffic(200);
        settle();
        write_cutoff(1);
        gen_traffic(150);
        settle();
        write_cutoff(65535);
        gen_traffic(200);
        settle();
        write_cutoff($urandom_range(65534, 2));
        gen_traffic(180);
        settle();

        // from here on no idling anywhere
        idle_pct = 0;
        write_cutoff($urandom_range(65534, 2));
        gen_traffic(180);
        settle();

        // long extreme-valued runs, back at the reset cutoff
        write_cutoff(CUTOFF_RESET);
        send_long_run(8'd7, LOD_MAX, DIFF_LIM);
        send_long_run(8'd8, LOD_MIN, -DIFF_LIM);
        settle();

        if (fail_count == 0 && regions_due.size() == 0)
            $display("** significant_site_region_merger_core: PASSED **");
        else
            $display("** significant_site_region_merger_core: FAILED **");
        $finish;
    end

    // Run limit: far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("** significant_site_region_merger_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
src/ssrm_pkg.sv
src/ssrm_divider.sv
src/ssrm_tracker.sv
src/significant_site_region_merger_core.sv
sim/tb.sv
